// File: design/rfd_pkg.sv
// Shared constants for the refraction direction pipeline.
package rfd_pkg;

  // Default number of fraction bits in the Q2.F vector format.
  localparam int FRAC_BITS_DEF = 16;

endpackage

// File: design/rfd_perp.sv
// Front pipeline: cosine term and saturated perpendicular part of the refracted direction.
module rfd_perp #(
  parameter int FRAC_BITS = rfd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [FRAC_BITS+2:0] a [3],
  input  logic signed [FRAC_BITS+2:0] n [3],
  input  logic        [FRAC_BITS+1:0] eta,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+2:0] p [3],
  output logic signed [FRAC_BITS+2:0] n_out [3]
);
  import rfd_pkg::*;

  localparam int W  = FRAC_BITS + 3;
  localparam int DW = 2 * W + 2;
  localparam int CW = DW + 1 - FRAC_BITS;
  localparam int NW = W + CW;
  localparam int TW = NW - FRAC_BITS + 1;
  localparam int EW = TW + W;
  localparam logic signed [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  // Stage 1: products of the dot product.
  logic                  v1;
  logic signed [W-1:0]   a1 [3];
  logic signed [W-1:0]   n1 [3];
  logic        [W-2:0]   e1;
  logic signed [2*W-1:0] prd1 [3];

  // Stage 2: clamped cosine.
  logic                  v2;
  logic signed [W-1:0]   a2 [3];
  logic signed [W-1:0]   n2 [3];
  logic        [W-2:0]   e2;
  logic signed [CW-1:0]  cos2;

  // Stage 3: normal scaled by the cosine.
  logic                  v3;
  logic signed [W-1:0]   a3 [3];
  logic signed [W-1:0]   n3 [3];
  logic        [W-2:0]   e3;
  logic signed [NW-1:0]  nc3 [3];

  // Stage 4: sum scaled by the index ratio.
  logic                  v4;
  logic signed [W-1:0]   n4 [3];
  logic signed [EW-1:0]  te4 [3];

  // Stage 5: saturated perpendicular part.
  logic                  v5;
  logic signed [W-1:0]   n5 [3];
  logic signed [W-1:0]   p5 [3];

  logic signed [DW-1:0]  dot;
  logic signed [DW:0]    ndot;
  logic signed [CW-1:0]  cos_c;
  logic signed [TW-1:0]  t [3];
  logic signed [W:0]     eta_s;
  logic signed [EW-1:0]  sh [3];
  logic signed [W-1:0]   p_c [3];

  always_comb begin
    dot   = DW'(prd1[0]) + DW'(prd1[1]) + DW'(prd1[2]);
    ndot  = -((DW+1)'(dot));
    cos_c = CW'(ndot >>> FRAC_BITS);
    if (cos_c > ONE_C) begin
      cos_c = ONE_C;
    end
    eta_s = $signed({1'b0, e3});
    for (int i = 0; i < 3; i++) begin
      t[i] = TW'(a3[i]) + TW'(nc3[i] >>> FRAC_BITS);
      sh[i] = te4[i] >>> FRAC_BITS;
      if ((&sh[i][EW-1:W-1]) || !(|sh[i][EW-1:W-1])) begin
        p_c[i] = sh[i][W-1:0];
      end else if (sh[i][EW-1]) begin
        p_c[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        p_c[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    e1   <= eta;
    e2   <= e1;
    e3   <= e2;
    cos2 <= cos_c;
    for (int i = 0; i < 3; i++) begin
      a1[i]   <= a[i];
      n1[i]   <= n[i];
      prd1[i] <= a[i] * n[i];
      a2[i]   <= a1[i];
      n2[i]   <= n1[i];
      a3[i]   <= a2[i];
      n3[i]   <= n2[i];
      nc3[i]  <= n2[i] * cos2;
      n4[i]   <= n3[i];
      te4[i]  <= t[i] * eta_s;
      n5[i]   <= n4[i];
      p5[i]   <= p_c[i];
    end
  end

  assign out_valid = v5;
  assign p         = p5;
  assign n_out     = n5;

endmodule

// File: design/rfd_isqrt.sv
// Pipelined truncating integer square root, one result bit per stage.
module rfd_isqrt #(
  parameter int FRAC_BITS = rfd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [2*(FRAC_BITS+3)-1:0]    rad,
  output logic                          out_valid,
  output logic [FRAC_BITS+2:0]          root
);
  import rfd_pkg::*;

  localparam int SW = FRAC_BITS + 3;
  localparam int RW = 2 * SW;

  logic [RW-1:0] rad_q  [SW+1];
  logic [SW:0]   rem_q  [SW+1];
  logic [SW-1:0] root_q [SW+1];
  logic          vld_q  [SW+1];

  always_comb begin
    rad_q[0]  = rad;
    rem_q[0]  = '0;
    root_q[0] = '0;
    vld_q[0]  = in_valid;
  end

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [SW+2:0] rem_sh;
    logic [SW+2:0] trial;
    logic          ge;

    always_comb begin
      rem_sh = {rem_q[k], rad_q[k][RW-1:RW-2]};
      trial  = {1'b0, root_q[k], 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
      rad_q[k+1]  <= rad_q[k] << 2;
      rem_q[k+1]  <= ge ? (SW+1)'(rem_sh - trial) : (SW+1)'(rem_sh);
      root_q[k+1] <= {root_q[k][SW-2:0], ge};
    end
  end

  assign out_valid = vld_q[SW];
  assign root      = root_q[SW];

endmodule

// File: design/refraction_direction_top.sv
// Top level of the Snell refraction pipeline.
//
// An item (incident direction, surface normal, index ratio) is taken at a
// rising edge where start is high and busy is low. Busy is always low: the
// block is a fully pipelined datapath and takes a new item in every cycle.
// The refracted direction appears on out_x, out_y and out_z for exactly one
// cycle, marked by done, and items come out in the order they went in.
// The pipeline length is set mostly by the square root, which resolves one
// root bit per stage.
// Throughput is one item per cycle.
// Reset clears every valid bit, so items in flight are dropped and no done
// pulse follows until new items arrive. The receiver cannot stall the block,
// so nothing is ever held back inside the pipeline.
// Arithmetic is signed Q2.F fixed point with floor shifts, saturation of the
// perpendicular part and of the result, and a truncating square root of the
// absolute value of one minus the squared perpendicular length.
module refraction_direction_top #(
  parameter int FRAC_BITS = rfd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [FRAC_BITS+2:0] dir_x,
  input  logic signed [FRAC_BITS+2:0] dir_y,
  input  logic signed [FRAC_BITS+2:0] dir_z,
  input  logic signed [FRAC_BITS+2:0] norm_x,
  input  logic signed [FRAC_BITS+2:0] norm_y,
  input  logic signed [FRAC_BITS+2:0] norm_z,
  input  logic        [FRAC_BITS+1:0] eta_ratio,
  output logic                        done,
  output logic signed [FRAC_BITS+2:0] out_x,
  output logic signed [FRAC_BITS+2:0] out_y,
  output logic signed [FRAC_BITS+2:0] out_z
);
  import rfd_pkg::*;

  localparam int W   = FRAC_BITS + 3;
  localparam int LW  = 2 * W + 2;
  localparam int QW  = 2 * W + 1;
  localparam int OW  = 2 * W + 2;
  localparam int LAT = W + 9;
  localparam logic signed [LW:0] ONE_SQ = (LW+1)'(1) << (2 * FRAC_BITS);

  logic                  acc;
  logic signed [W-1:0]   a_in [3];
  logic signed [W-1:0]   n_in [3];

  // Front part: perpendicular component.
  logic                  v5;
  logic signed [W-1:0]   p5 [3];
  logic signed [W-1:0]   n5 [3];

  // Squared length and radicand.
  logic                  v6;
  logic signed [2*W-1:0] sq6 [3];
  logic                  v7;
  logic        [2*W-1:0] rad7;
  logic signed [W-1:0]   pd [W+2][3];
  logic signed [W-1:0]   nd [W+2][3];

  // Square root output and the parallel part.
  logic                  sq_valid;
  logic        [W-1:0]   root;
  logic                  v8;
  logic signed [QW-1:0]  ns8 [3];
  logic signed [W-1:0]   p8 [3];

  logic signed [LW-1:0]  l2;
  logic signed [LW:0]    diff;
  logic signed [W:0]     root_s;
  logic signed [OW-1:0]  sum [3];
  logic signed [W-1:0]   res [3];

  // The pipeline never holds an item back, so busy stays low.
  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign a_in[0] = dir_x;
  assign a_in[1] = dir_y;
  assign a_in[2] = dir_z;
  assign n_in[0] = norm_x;
  assign n_in[1] = norm_y;
  assign n_in[2] = norm_z;

  rfd_perp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_perp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (acc),
    .a        (a_in),
    .n        (n_in),
    .eta      (eta_ratio),
    .out_valid(v5),
    .p        (p5),
    .n_out    (n5)
  );

  // Radicand is the magnitude of one minus the squared length, at 2F fraction bits.
  always_comb begin
    l2   = LW'(sq6[0]) + LW'(sq6[1]) + LW'(sq6[2]);
    diff = ONE_SQ - (LW+1)'(l2);
    if (diff < 0) begin
      diff = -diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v6 <= v5;
      v7 <= v6;
    end
    rad7 <= diff[2*W-1:0];
    for (int i = 0; i < 3; i++) begin
      sq6[i] <= p5[i] * p5[i];
    end
  end

  rfd_isqrt #(
    .FRAC_BITS(FRAC_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v7),
    .rad      (rad7),
    .out_valid(sq_valid),
    .root     (root)
  );

  // The perpendicular part and the normal ride alongside the square root.
  // The first tap sits level with the squared length, so the line is one
  // stage deeper than the square root, matching the radicand register.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pd[0][i] <= p5[i];
      nd[0][i] <= n5[i];
    end
    for (int k = 0; k < W + 1; k++) begin
      for (int i = 0; i < 3; i++) begin
        pd[k+1][i] <= pd[k][i];
        nd[k+1][i] <= nd[k][i];
      end
    end
  end

  assign root_s = $signed({1'b0, root});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = ((-(OW'(ns8[i]))) >>> FRAC_BITS) + OW'(p8[i]);
      if ((&sum[i][OW-1:W-1]) || !(|sum[i][OW-1:W-1])) begin
        res[i] = sum[i][W-1:0];
      end else if (sum[i][OW-1]) begin
        res[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8   <= 1'b0;
      done <= 1'b0;
    end else begin
      v8   <= sq_valid;
      done <= v8;
    end
    for (int i = 0; i < 3; i++) begin
      ns8[i] <= nd[W+1][i] * root_s;
      p8[i]  <= pd[W+1][i];
    end
    out_x <= res[0];
    out_y <= res[1];
    out_z <= res[2];
  end

  // Every result traces back to an item accepted a fixed latency earlier.
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LAT))
    else $error("result without a matching item");

  // Every accepted item yields a result after the fixed latency.
  a_item_has_done: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##LAT done)
    else $error("item lost in the pipeline");

  // The square root stage keeps step with the radicand register.
  a_sqrt_aligned: assert property (@(posedge clk) disable iff (rst)
    sq_valid |-> $past(v7, W))
    else $error("square root output out of step");

endmodule
